### src/ipv4_relay_header_rewrite_defines.svh
// assertion macros shared by the relay rewrite design
`ifndef IPV4_RELAY_HEADER_REWRITE_DEFINES_SVH
`define IPV4_RELAY_HEADER_REWRITE_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define IRHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define IRHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/irhr_pkg.sv
`timescale 1ns / 1ps

package irhr_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    // register reset values
    localparam logic [31:0] RST_HOST_A_IP      = 32'h0A00_0002;
    localparam logic [31:0] RST_HOST_B_IP      = 32'h0A00_0003;
    localparam logic [31:0] RST_GATEWAY_IP     = 32'h0A00_000A;
    localparam logic [31:0] RST_MAC_PREFIX     = 32'hDEAD_BEEF;
    localparam logic [7:0]  RST_HOST_A_MAC_LOW = 8'h02;
    localparam logic [7:0]  RST_HOST_B_MAC_LOW = 8'h03;
    localparam logic [7:0]  RST_GW_MAC_LOW     = 8'h0A;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_HOST_A_IP      = 3'd0,
        REG_HOST_B_IP      = 3'd1,
        REG_GATEWAY_IP     = 3'd2,
        REG_MAC_PREFIX     = 3'd3,
        REG_HOST_A_MAC_LOW = 3'd4,
        REG_HOST_B_MAC_LOW = 3'd5,
        REG_GW_MAC_LOW     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] host_a_ip;
        logic [31:0] host_b_ip;
        logic [31:0] gateway_ip;
        logic [31:0] mac_prefix;
        logic [7:0]  host_a_mac_low;
        logic [7:0]  host_b_mac_low;
        logic [7:0]  gateway_mac_low;
    } t_cfg;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [15:0] ver_ihl_tos;
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [15:0] flags_fragment;
        logic [15:0] ttl_proto;
        logic [31:0] in_src_ip;
    } t_hdr;

    typedef struct packed {
        logic        action;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] out_src_ip;
        logic [31:0] out_dst_ip;
        logic [15:0] header_checksum;
    } t_result;

endpackage

### src/ipv4_relay_header_rewrite.sv
`timescale 1ns / 1ps
// r_hdr and r_in_valid register the word, r_res and r_out_valid the result
// throughput: one word per cycle, o_busy is always low
// the receiver cannot stall: o_valid is high for exactly one cycle per word
// synchronous active-low reset clears the valid flags and loads register defaults
`include "ipv4_relay_header_rewrite_defines.svh"

module ipv4_relay_header_rewrite (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command side
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_ether_type,
    input  logic [15:0] i_ver_ihl_tos,
    input  logic [15:0] i_total_length,
    input  logic [15:0] i_ident,
    input  logic [15:0] i_flags_fragment,
    input  logic [15:0] i_ttl_proto,
    input  logic [31:0] i_in_src_ip,
    // result side
    output logic        o_valid,
    output logic        o_action,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [31:0] o_out_src_ip,
    output logic [31:0] o_out_dst_ip,
    output logic [15:0] o_header_checksum
);

    irhr_pkg::t_cfg    r_cfg;
    irhr_pkg::t_hdr    r_hdr;
    irhr_pkg::t_result w_res;
    irhr_pkg::t_result r_res;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_wr;
    logic              w_accept;
    logic [2:0]        w_idx;

    assign pready   = 1'b1;
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_wr     = psel && penable && pwrite && pready;
    assign w_idx    = paddr[4:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_a_ip       <= irhr_pkg::RST_HOST_A_IP;
            r_cfg.host_b_ip       <= irhr_pkg::RST_HOST_B_IP;
            r_cfg.gateway_ip      <= irhr_pkg::RST_GATEWAY_IP;
            r_cfg.mac_prefix      <= irhr_pkg::RST_MAC_PREFIX;
            r_cfg.host_a_mac_low  <= irhr_pkg::RST_HOST_A_MAC_LOW;
            r_cfg.host_b_mac_low  <= irhr_pkg::RST_HOST_B_MAC_LOW;
            r_cfg.gateway_mac_low <= irhr_pkg::RST_GW_MAC_LOW;
        end else if (w_wr) begin
            unique case (w_idx)
                irhr_pkg::REG_HOST_A_IP:      r_cfg.host_a_ip       <= pwdata;
                irhr_pkg::REG_HOST_B_IP:      r_cfg.host_b_ip       <= pwdata;
                irhr_pkg::REG_GATEWAY_IP:     r_cfg.gateway_ip      <= pwdata;
                irhr_pkg::REG_MAC_PREFIX:     r_cfg.mac_prefix      <= pwdata;
                irhr_pkg::REG_HOST_A_MAC_LOW: r_cfg.host_a_mac_low  <= pwdata[7:0];
                irhr_pkg::REG_HOST_B_MAC_LOW: r_cfg.host_b_mac_low  <= pwdata[7:0];
                irhr_pkg::REG_GW_MAC_LOW:     r_cfg.gateway_mac_low <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_idx)
            irhr_pkg::REG_HOST_A_IP:      prdata = r_cfg.host_a_ip;
            irhr_pkg::REG_HOST_B_IP:      prdata = r_cfg.host_b_ip;
            irhr_pkg::REG_GATEWAY_IP:     prdata = r_cfg.gateway_ip;
            irhr_pkg::REG_MAC_PREFIX:     prdata = r_cfg.mac_prefix;
            irhr_pkg::REG_HOST_A_MAC_LOW: prdata = {24'h0, r_cfg.host_a_mac_low};
            irhr_pkg::REG_HOST_B_MAC_LOW: prdata = {24'h0, r_cfg.host_b_mac_low};
            irhr_pkg::REG_GW_MAC_LOW:     prdata = {24'h0, r_cfg.gateway_mac_low};
            default:                      prdata = 32'h0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr.ether_type     <= i_ether_type;
            r_hdr.ver_ihl_tos    <= i_ver_ihl_tos;
            r_hdr.total_length   <= i_total_length;
            r_hdr.ident          <= i_ident;
            r_hdr.flags_fragment <= i_flags_fragment;
            r_hdr.ttl_proto      <= i_ttl_proto;
            r_hdr.in_src_ip      <= i_in_src_ip;
        end
    end

    // decision and checksum logic
    irhr_core u_core (
        .i_cfg (r_cfg),
        .i_hdr (r_hdr),
        .o_res (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res <= w_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_action          = r_res.action;
    assign o_dst_mac         = r_res.dst_mac;
    assign o_src_mac         = r_res.src_mac;
    assign o_out_src_ip      = r_res.out_src_ip;
    assign o_out_dst_ip      = r_res.out_dst_ip;
    assign o_header_checksum = r_res.header_checksum;

    // checks
    `IRHR_ASSERT_NEXT(a_accept_loads, w_accept, r_in_valid, "accepted word not registered")
    `IRHR_ASSERT_NEXT(a_no_spurious, !r_in_valid, !o_valid, "result strobe without a word")
    `IRHR_ASSERT_NOW(a_drop_zero, o_valid && !o_action,
        (o_header_checksum == 16'h0) && (o_dst_mac == 48'h0) && (o_out_dst_ip == 32'h0),
        "dropped word carries nonzero fields")
    `IRHR_ASSERT_NEXT(a_fwd_ipv4, r_in_valid && w_res.action,
        o_valid && o_action && ($past(r_hdr.ether_type) == irhr_pkg::ETHERTYPE_IPV4),
        "forwarded word was not ipv4")

endmodule

### src/irhr_core.sv
`timescale 1ns / 1ps

module irhr_core (
    input  irhr_pkg::t_cfg    i_cfg,
    input  irhr_pkg::t_hdr    i_hdr,
    output irhr_pkg::t_result o_res
);

    logic        w_is_ipv4;
    logic        w_from_a;
    logic        w_from_b;
    logic [31:0] w_peer_ip;
    logic [7:0]  w_peer_mac;
    logic [19:0] w_sum;
    logic [16:0] w_fold1;
    logic [16:0] w_fold2;

    // classify the frame and pick the peer, host a match wins
    always_comb begin
        w_is_ipv4 = (i_hdr.ether_type == irhr_pkg::ETHERTYPE_IPV4);
        w_from_a  = (i_hdr.in_src_ip == i_cfg.host_a_ip);
        w_from_b  = (i_hdr.in_src_ip == i_cfg.host_b_ip);
        priority if (w_from_a) begin
            w_peer_ip  = i_cfg.host_b_ip;
            w_peer_mac = i_cfg.host_b_mac_low;
        end else begin
            w_peer_ip  = i_cfg.host_a_ip;
            w_peer_mac = i_cfg.host_a_mac_low;
        end
    end

    // ones'-complement sum of the base header, check word as zero
    always_comb begin
        w_sum = 20'(i_hdr.ver_ihl_tos) + 20'(i_hdr.total_length) + 20'(i_hdr.ident)
              + 20'(i_hdr.flags_fragment) + 20'(i_hdr.ttl_proto)
              + 20'(i_cfg.gateway_ip[31:16]) + 20'(i_cfg.gateway_ip[15:0])
              + 20'(w_peer_ip[31:16]) + 20'(w_peer_ip[15:0]);
        w_fold1 = 17'(w_sum[15:0]) + 17'(w_sum[19:16]);
        w_fold2 = 17'(w_fold1[15:0]) + 17'(w_fold1[16]);
    end

    // result word, all zero on drop
    always_comb begin
        o_res = '0;
        if (w_is_ipv4 && (w_from_a || w_from_b)) begin
            o_res.action          = 1'b1;
            o_res.dst_mac         = {i_cfg.mac_prefix, 8'h00, w_peer_mac};
            o_res.src_mac         = {i_cfg.mac_prefix, 8'h00, i_cfg.gateway_mac_low};
            o_res.out_src_ip      = i_cfg.gateway_ip;
            o_res.out_dst_ip      = w_peer_ip;
            o_res.header_checksum = ~w_fold2[15:0];
        end
    end

endmodule
